[rtl/mal_pkg.sv]
`timescale 1ns / 1ps
// package for the mru address list: list depth, field widths, request codes
// and the control bundle broadcast to every list cell; depends on nothing

package mal_pkg;

    localparam int LIST_DEPTH = 4;
    localparam int ADDR_W     = 48;
    localparam int MODE_W     = 2;
    localparam int FIELD_W    = 3;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    // request codes; the unused code behaves as lookup
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

    // status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    // position reported for an absent address, cut to the field width
    localparam logic [FIELD_W-1:0] ABSENT_POS = FIELD_W'(LIST_DEPTH);

    typedef struct packed {
        logic              add_en;
        logic              del_en;
        logic [ADDR_W-1:0] addr;
    } cell_ctl_t;

endpackage

[rtl/mal_cell.sv]
`timescale 1ns / 1ps
// one slot of the mru address list: compares against the request address,
// passes the hit flag down the chain and shifts with its neighbors; uses mal_pkg

module mal_cell
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mal_pkg::cell_ctl_t         ctl,
    input  logic [mal_pkg::ADDR_W-1:0] front_data,
    input  logic [mal_pkg::ADDR_W-1:0] back_data,
    input  logic                       hit_in,
    output logic                       hit_out,
    output logic                       hit,
    output logic [mal_pkg::ADDR_W-1:0] slot
);

    logic [mal_pkg::ADDR_W-1:0] slot_reg;
    logic [mal_pkg::ADDR_W-1:0] slot_next;

    // zero marks an empty slot and never matches
    assign hit     = (slot_reg == ctl.addr) && (ctl.addr != '0);
    assign hit_out = hit_in | hit;
    assign slot    = slot_reg;

    always_comb
    begin
        slot_next = slot_reg;
        if (ctl.add_en && !hit_in)
        begin
            // every slot up to and including the match takes its front neighbor
            slot_next = front_data;
        end
        else if (ctl.del_en && hit_out)
        begin
            // the match and everything behind it close the gap
            slot_next = back_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

[rtl/mru_address_list.sv]
`timescale 1ns / 1ps
// top level of the mru address list: request decode, chain of list cells,
// occupancy counter and result register; uses mal_pkg and mal_cell
//
// usage
//   input channel: in_valid / in_stall with mode and address. mode 0 adds an
//   address or promotes it to the front, 1 deletes it, 2 (and 3) look it up.
//   output channel: out_valid / out_stall with status, found, position and
//   occupied, exactly one result per request, in request order.
//   throughput: one request per cycle unless stalled. every cell compares its
//   slot against the request and shifts to or from its neighbor in the same
//   cycle, so the next request sees the updated list right away.
//   result: the result is registered and appears on the output register in
//   the cycle after the transfer is taken.
//   stall: while a result waits and out_stall is high, in_stall is raised and
//   no request is taken; a waiting result is held stable. when the receiver
//   takes the result, a new request may transfer in that same cycle.
//   reset: rst_n clears every slot (empty list), the occupancy count and the
//   output valid; in_stall is low out of reset, so the block is ready at once.
//   zero addresses never match; deleting zero reports status rejected and
//   adding zero leaves the list untouched.

module mru_address_list
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [mal_pkg::MODE_W-1:0]  mode,
    input  logic [mal_pkg::ADDR_W-1:0]  address,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        status,
    output logic                        found,
    output logic [mal_pkg::FIELD_W-1:0] position,
    output logic [mal_pkg::FIELD_W-1:0] occupied
);

    localparam int DEPTH = mal_pkg::LIST_DEPTH;

    logic                        in_xfer;
    logic                        addr_nz;
    logic                        is_add;
    logic                        is_del;
    mal_pkg::cell_ctl_t          ctl;

    logic [mal_pkg::ADDR_W-1:0]  slot_q [DEPTH];
    logic [mal_pkg::ADDR_W-1:0]  front_d [DEPTH];
    logic [mal_pkg::ADDR_W-1:0]  back_d [DEPTH];
    logic [DEPTH:0]              hit_chain;
    logic [DEPTH-1:0]            hit_vec;
    logic [DEPTH-1:0]            nz_vec;

    logic                        any_hit;
    logic [mal_pkg::FIELD_W-1:0] hit_pos;
    logic                        res_status;

    logic [mal_pkg::CNT_W-1:0]   occ_reg;
    logic [mal_pkg::CNT_W-1:0]   occ_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        status_reg;
    logic                        found_reg;
    logic [mal_pkg::FIELD_W-1:0] position_reg;
    logic [mal_pkg::FIELD_W-1:0] occupied_reg;

    // a new request can come in whenever the result register is free or draining
    assign in_stall = out_valid_reg & out_stall;
    assign in_xfer  = in_valid & ~in_stall;

    // request decode
    assign addr_nz = (address != '0);
    assign is_add  = (mode == mal_pkg::MODE_ADD);
    assign is_del  = (mode == mal_pkg::MODE_DELETE);

    assign ctl.add_en = in_xfer & is_add & addr_nz;
    assign ctl.del_en = in_xfer & is_del;
    assign ctl.addr   = address;

    // chain of cells; slot 0 is the front and takes the new address on add
    assign hit_chain[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        if (g == 0)
        begin : g_front
            assign front_d[g] = address;
        end
        else
        begin : g_mid
            assign front_d[g] = slot_q[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_back
            assign back_d[g] = '0;
        end
        else
        begin : g_inner
            assign back_d[g] = slot_q[g+1];
        end

        mal_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .front_data (front_d[g]),
            .back_data  (back_d[g]),
            .hit_in     (hit_chain[g]),
            .hit_out    (hit_chain[g+1]),
            .hit        (hit_vec[g]),
            .slot       (slot_q[g])
        );

        assign nz_vec[g] = (slot_q[g] != '0);
    end

    assign any_hit = hit_chain[DEPTH];

    // first matching slot; the list never holds a duplicate
    always_comb
    begin
        hit_pos = mal_pkg::ABSENT_POS;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_pos = mal_pkg::FIELD_W'(i);
            end
        end
    end

    assign res_status = (is_del && !addr_nz) ? mal_pkg::STATUS_REJECTED
                                             : mal_pkg::STATUS_OK;

    // occupancy follows the list: a fresh add grows it until full,
    // a delete that hits shrinks it
    always_comb
    begin
        occ_next = occ_reg;
        if (ctl.add_en && !any_hit && (occ_reg != mal_pkg::CNT_W'(DEPTH)))
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (ctl.del_en && any_hit)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_xfer)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded only on a transfer so a stalled result holds
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            status_reg   <= res_status;
            found_reg    <= any_hit;
            position_reg <= hit_pos;
            occupied_reg <= mal_pkg::FIELD_W'(occ_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign position  = position_reg;
    assign occupied  = occupied_reg;

    // occupied slots always form an unbroken run from the front
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        ((nz_vec + 1'b1) & nz_vec) == '0)
        else $error("occupied slots are not contiguous");

    // the counter agrees with the nonzero slots
    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == mal_pkg::CNT_W'($countones(nz_vec)))
        else $error("occupancy count out of step with the list");

    // an add of a nonzero address lands in the front slot
    a_add_front: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && is_add && addr_nz) |=> (slot_q[0] == $past(address)))
        else $error("added address not at the front");

    // a rejected delete never reports a hit
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == mal_pkg::STATUS_REJECTED)) |-> !found_reg)
        else $error("rejected request reports found");

    // at most one slot matches any address
    a_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("duplicate address in the list");

endmodule
